// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the run generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define RSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define RSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/rsr_pkg.sv =====
// Package with the constants and types of the replacement-selection run generator.
package rsr_pkg;

    localparam int MEM_DEPTH = 16;
    localparam int REC_W     = 32;
    localparam int CFG_W     = 5;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
    localparam int CFG_RESET = 16;

    localparam logic signed [REC_W-1:0] REC_MIN = {1'b1, {(REC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/rsr_if.sv =====
// Stream interfaces for the input records and the emitted run records.
interface rsr_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsr_pkg::REC_W-1:0]  record;
    logic                              is_final;

    modport source (output valid, output record, output is_final, input ready);
    modport sink   (input valid, input record, input is_final, output ready);
endinterface

interface rsr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsr_pkg::REC_W-1:0]  out_record;
    logic                              run_end;
    logic                              last;

    modport source (output valid, output out_record, output run_end, output last,
                    input ready);
    modport sink   (input valid, input out_record, input run_end, input last,
                    output ready);
endinterface

// ===== rtl/core/replacement_selection_runs_top.sv =====
// Top level of the replacement-selection run generator for an external sort.
//
// This block turns a stream of signed 32-bit records into sorted runs by replacement
// selection. The first records (as many as the r_cfg register allows, held to the
// range one to sixteen) only fill the store and give no output. Every later record
// causes the smallest unfrozen stored record to be sent out, and the new record takes
// its slot; it is frozen for the rest of the run if it is smaller than the record
// just sent. When no unfrozen record is left, that output carries run_end and the
// whole store thaws for the next run. A record with is_final set is taken in the
// same way and then the store is drained by the same rule, so one input transaction
// may give up to seventeen output transactions, the last of which carries last.
// Sequence: a record that only fills the store is written as it is taken. A record
// that causes a selection is taken in ST_IDLE; then in ST_SCAN a single signed
// comparator steps through the slots one per cycle, and ST_EMIT sends the result
// and writes the new record back; a selection that finds every record frozen thaws
// the store and scans again. A final record then goes through a scan and an emit
// for each record drained. The write-back state waits as long as the previous result
// is still unread in the output register. The input is not ready while an item is
// being worked on; a finished result waits in the output register without holding
// back the input. Configuration writes are meant for times when the block is idle.
module replacement_selection_runs_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsr_pkg::CFG_W-1:0]     i_cfg_wdata,
    rsr_in_if.sink                        i_in,
    rsr_out_if.source                     o_out
);

`include "assert_macros.svh"

    // Store of records: one write port, one read port at the scan index.
    logic signed [rsr_pkg::REC_W-1:0] r_store [rsr_pkg::MEM_DEPTH];

    rsr_pkg::t_state                  r_state,     n_state;
    logic [rsr_pkg::CFG_W-1:0]        r_cfg;
    logic [rsr_pkg::MEM_DEPTH-1:0]    r_valid,     n_valid;
    logic [rsr_pkg::MEM_DEPTH-1:0]    r_frozen,    n_frozen;
    logic [rsr_pkg::CNT_W-1:0]        r_fill,      n_fill;
    logic signed [rsr_pkg::REC_W-1:0] r_last_em,   n_last_em;
    logic signed [rsr_pkg::REC_W-1:0] r_rec,       n_rec;
    logic                             r_fin,       n_fin;
    logic                             r_drain,     n_drain;
    logic [rsr_pkg::IDX_W-1:0]        r_idx,       n_idx;
    logic                             r_found,     n_found;
    logic [rsr_pkg::IDX_W-1:0]        r_best_idx,  n_best_idx;
    logic signed [rsr_pkg::REC_W-1:0] r_best_val,  n_best_val;
    logic                             r_out_valid, n_out_valid;
    logic signed [rsr_pkg::REC_W-1:0] r_out_rec,   n_out_rec;
    logic                             r_out_end,   n_out_end;
    logic                             r_out_last,  n_out_last;
    logic signed [rsr_pkg::REC_W-1:0] r_scan_val;

    logic                             w_we;
    logic [rsr_pkg::IDX_W-1:0]        w_addr;
    logic signed [rsr_pkg::REC_W-1:0] w_data;

    logic [rsr_pkg::CNT_W-1:0]        slots;
    logic [rsr_pkg::IDX_W-1:0]        free_idx;
    logic                             in_acc;
    logic                             out_free;
    logic                             take;
    logic                             emit_last;

    // Effective slot count: zero acts as one, anything above the depth as the depth.
    always_comb begin
        if (r_cfg == '0) begin
            slots = rsr_pkg::CNT_W'(1);
        end else if (int'(r_cfg) > rsr_pkg::MEM_DEPTH) begin
            slots = rsr_pkg::CNT_W'(rsr_pkg::MEM_DEPTH);
        end else begin
            slots = rsr_pkg::CNT_W'(r_cfg);
        end
    end

    // Lowest-numbered empty slot, used when a record only fills the store.
    always_comb begin
        free_idx = '0;
        for (int i = rsr_pkg::MEM_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = rsr_pkg::IDX_W'(i);
            end
        end
    end

    assign i_in.ready = (r_state == rsr_pkg::ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // The shared comparator: the slot under the scan index against the best so far.
    // A strict compare keeps the lowest-numbered slot on ties.
    assign take     = r_valid[r_idx] && !r_frozen[r_idx] &&
                      (!r_found || (r_scan_val < r_best_val));

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_frozen    = r_frozen;
        n_fill      = r_fill;
        n_last_em   = r_last_em;
        n_rec       = r_rec;
        n_fin       = r_fin;
        n_drain     = r_drain;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_out_valid = r_out_valid;
        n_out_rec   = r_out_rec;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_addr      = r_best_idx;
        w_data      = r_rec;
        emit_last   = 1'b0;

        // The consumer takes the waiting result unless a new one replaces it below.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rsr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_rec   = i_in.record;
                    n_fin   = i_in.is_final;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (r_fill < slots) begin
                        // Filling phase: the record just goes into an empty slot.
                        w_we               = 1'b1;
                        w_addr             = free_idx;
                        w_data             = i_in.record;
                        n_valid[free_idx]  = 1'b1;
                        n_frozen[free_idx] = (i_in.record < r_last_em);
                        n_fill             = r_fill + rsr_pkg::CNT_W'(1);
                        n_drain            = 1'b1;
                        if (i_in.is_final) begin
                            n_state = rsr_pkg::ST_SCAN;
                        end
                    end else begin
                        n_drain = 1'b0;
                        n_state = rsr_pkg::ST_SCAN;
                    end
                end
            end

            rsr_pkg::ST_SCAN: begin
                if (take) begin
                    n_found    = 1'b1;
                    n_best_idx = r_idx;
                    n_best_val = r_scan_val;
                end
                if (r_idx == rsr_pkg::IDX_W'(rsr_pkg::MEM_DEPTH - 1)) begin
                    n_idx = '0;
                    if (r_found || take) begin
                        n_state = rsr_pkg::ST_EMIT;
                    end else begin
                        // Every stored record is frozen: thaw and start a new run.
                        n_frozen  = '0;
                        n_last_em = rsr_pkg::REC_MIN;
                        n_found   = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + rsr_pkg::IDX_W'(1);
                end
            end

            rsr_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (r_drain) begin
                        n_valid[r_best_idx]  = 1'b0;
                        n_frozen[r_best_idx] = 1'b0;
                        n_fill               = r_fill - rsr_pkg::CNT_W'(1);
                        emit_last            = (n_fill == '0);
                    end else begin
                        w_we                 = 1'b1;
                        n_frozen[r_best_idx] = (r_rec < r_best_val);
                        emit_last            = !r_fin;
                    end

                    n_out_valid = 1'b1;
                    n_out_rec   = r_best_val;
                    n_out_last  = emit_last;
                    n_out_end   = ~|(n_valid & ~n_frozen);

                    // Closing a run thaws the store; otherwise the bound moves up.
                    if (n_out_end) begin
                        n_frozen  = '0;
                        n_last_em = rsr_pkg::REC_MIN;
                    end else begin
                        n_last_em = r_best_val;
                    end

                    n_found = 1'b0;
                    n_idx   = '0;
                    if (emit_last) begin
                        if (r_drain) begin
                            n_frozen  = '0;
                            n_last_em = rsr_pkg::REC_MIN;
                        end
                        n_state = rsr_pkg::ST_IDLE;
                    end else begin
                        n_drain = 1'b1;
                        n_state = rsr_pkg::ST_SCAN;
                    end
                end
            end

            default: begin
                n_state = rsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsr_pkg::ST_IDLE;
            r_cfg       <= rsr_pkg::CFG_W'(rsr_pkg::CFG_RESET);
            r_valid     <= '0;
            r_frozen    <= '0;
            r_fill      <= '0;
            r_last_em   <= rsr_pkg::REC_MIN;
            r_drain     <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_valid     <= n_valid;
            r_frozen    <= n_frozen;
            r_fill      <= n_fill;
            r_last_em   <= n_last_em;
            r_drain     <= n_drain;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec      <= n_rec;
        r_fin      <= n_fin;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_out_rec  <= n_out_rec;
        r_out_end  <= n_out_end;
        r_out_last <= n_out_last;
    end

    // The read port follows the next scan index, so the word of a slot is on hand in
    // the cycle that the scan looks at it; a write to that slot at the same edge is
    // passed straight through.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_addr] <= w_data;
        end
        if (w_we && (w_addr == n_idx)) begin
            r_scan_val <= w_data;
        end else begin
            r_scan_val <= r_store[n_idx];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_record = r_out_rec;
    assign o_out.run_end    = r_out_end;
    assign o_out.last       = r_out_last;

    // The fill count always matches the number of occupied slots.
    `RSR_ASSERT(a_fill_matches_valid, i_clk, i_rst_n,
        r_fill == rsr_pkg::CNT_W'($countones(r_valid)),
        "fill count differs from occupied slots")
    // The slot chosen for output is occupied and unfrozen.
    `RSR_ASSERT(a_best_is_live, i_clk, i_rst_n,
        (r_state == rsr_pkg::ST_EMIT) |-> (r_valid[r_best_idx] && !r_frozen[r_best_idx]),
        "selected slot is empty or frozen")
    // The result marked last returns the sequencer to idle.
    `RSR_ASSERT(a_last_ends_item, i_clk, i_rst_n,
        (r_state == rsr_pkg::ST_EMIT && out_free && emit_last) |=> (r_state == rsr_pkg::ST_IDLE),
        "item did not finish after its last result")
    // Reset leaves an empty store and an idle sequencer.
    `RSR_ASSERT_ALWAYS(a_reset_state, i_clk,
        !i_rst_n |=> (r_state == rsr_pkg::ST_IDLE && r_fill == '0 && !r_out_valid),
        "reset did not clear the control state")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the replacement-selection run generator.
`timescale 1ns / 100ps

module testbench;

    // Largest signed record, the counterpart of the package's REC_MIN.
    localparam logic signed [rsr_pkg::REC_W-1:0] REC_TOP =
        {1'b0, {(rsr_pkg::REC_W-1){1'b1}}};
    // Cycles allowed for the block to settle once no result is outstanding. A record
    // that only fills the store gives no result, and a selection that has to thaw and
    // scan again still finishes well within it, so this leaves a wide margin.
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_RECORDS = 390;
    localparam int HOLD_CYCLES    = 400;

    typedef enum int {
        VAL_FULL,
        VAL_TIES,
        VAL_RISING,
        VAL_FALLING,
        VAL_EDGES
    } t_value_mode;

    typedef struct {
        logic signed [rsr_pkg::REC_W-1:0] value;
        logic                             run_end;
        logic                             last;
    } t_run_rec;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [rsr_pkg::CFG_W-1:0] cfg_wdata;

    rsr_in_if  in_if ();
    rsr_out_if out_if ();

    replacement_selection_runs_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the selection store and the register.
    // ------------------------------------------------------------------------
    logic signed [rsr_pkg::REC_W-1:0] sto_val [rsr_pkg::MEM_DEPTH];
    logic                             sto_frz [rsr_pkg::MEM_DEPTH];
    logic                             sto_vld [rsr_pkg::MEM_DEPTH];
    int                               fill_cnt;
    logic signed [rsr_pkg::REC_W-1:0] last_out;
    logic [rsr_pkg::CFG_W-1:0]        slots_cfg;

    // Run records that the block still owes us, oldest first.
    t_run_rec expected_runs [$];

    int   mismatches = 0;
    bit   idle_on    = 1'b0;
    // Set by a test to ask the receiver for one long hold-off; the receiver counts it.
    int   hold_len   = 0;
    bit   hold_taken = 1'b0;
    int   hold_left  = 0;
    int   sink_gap   = 0;
    logic signed [rsr_pkg::REC_W-1:0] walk;

    // Appends one run record to the tail of the expected list.
    function automatic void queue_expected(input t_run_rec item);
        expected_runs = {expected_runs, item};
    endfunction

    // The register is held to the range one to MEM_DEPTH.
    function automatic int effective_slots();
        if (slots_cfg == '0) begin
            return 1;
        end
        if (int'(slots_cfg) > rsr_pkg::MEM_DEPTH) begin
            return rsr_pkg::MEM_DEPTH;
        end
        return int'(slots_cfg);
    endfunction

    // Lowest-numbered stored, unfrozen slot holding the smallest value, or -1.
    function automatic int smallest_open();
        int best;
        int i;
        best = -1;
        for (i = 0; i < rsr_pkg::MEM_DEPTH; i++) begin
            if (sto_vld[i] && !sto_frz[i]) begin
                if (best < 0) begin
                    best = i;
                end else if (sto_val[i] < sto_val[best]) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    function automatic void thaw_store();
        int i;
        for (i = 0; i < rsr_pkg::MEM_DEPTH; i++) begin
            sto_frz[i] = 1'b0;
        end
        last_out = rsr_pkg::REC_MIN;
    endfunction

    // A selection that finds everything frozen starts a new run without a mark.
    function automatic int choose_slot();
        int slot;
        slot = smallest_open();
        if (slot < 0 && fill_cnt > 0) begin
            thaw_store();
            slot = smallest_open();
        end
        return slot;
    endfunction

    // Works out the run records that one accepted input transaction causes.
    function automatic void take_record(input logic signed [rsr_pkg::REC_W-1:0] rec,
                                        input logic fin);
        t_run_rec held;
        bit       have_held;
        bit       placed;
        int       slot;
        int       i;
        held      = '{value: '0, run_end: 1'b0, last: 1'b0};
        have_held = 1'b0;
        placed    = 1'b0;
        if (fill_cnt < effective_slots()) begin
            for (i = 0; i < rsr_pkg::MEM_DEPTH; i++) begin
                if (!placed && !sto_vld[i]) begin
                    sto_val[i] = rec;
                    sto_frz[i] = rec < last_out;
                    sto_vld[i] = 1'b1;
                    fill_cnt++;
                    placed = 1'b1;
                end
            end
        end else begin
            slot = choose_slot();
            if (slot >= 0) begin
                held.value    = sto_val[slot];
                held.run_end  = 1'b0;
                have_held     = 1'b1;
                last_out      = sto_val[slot];
                sto_val[slot] = rec;
                sto_frz[slot] = rec < last_out;
                if (smallest_open() < 0) begin
                    held.run_end = 1'b1;
                    thaw_store();
                end
            end
        end
        if (fin) begin
            slot = 0;
            while (fill_cnt > 0 && slot >= 0) begin
                slot = choose_slot();
                if (slot >= 0) begin
                    if (have_held) begin
                        queue_expected(held);
                    end
                    held.value    = sto_val[slot];
                    held.run_end  = 1'b0;
                    have_held     = 1'b1;
                    last_out      = sto_val[slot];
                    sto_vld[slot] = 1'b0;
                    sto_frz[slot] = 1'b0;
                    fill_cnt--;
                    if (smallest_open() < 0) begin
                        held.run_end = 1'b1;
                        thaw_store();
                    end
                end
            end
            thaw_store();
        end
        if (have_held) begin
            held.last = 1'b1;
            queue_expected(held);
        end
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [rsr_pkg::REC_W-1:0] draw_record(input t_value_mode mode);
        case (mode)
            VAL_TIES: begin
                return $signed($urandom_range(0, 7)) - 4;
            end
            VAL_RISING: begin
                walk = walk + $urandom_range(0, 100);
                return walk;
            end
            VAL_FALLING: begin
                walk = walk - $urandom_range(0, 100);
                return walk;
            end
            VAL_EDGES: begin
                case ($urandom_range(0, 6))
                    0: return rsr_pkg::REC_MIN;
                    1: return rsr_pkg::REC_MIN + 1;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return REC_TOP - 1;
                    default: return REC_TOP;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Register settings, weighted towards the ends of the range and small counts.
    function automatic logic [rsr_pkg::CFG_W-1:0] pick_slot_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return rsr_pkg::CFG_W'(1);
            2: return rsr_pkg::CFG_W'(rsr_pkg::MEM_DEPTH);
            3: return '1;
            4: return rsr_pkg::CFG_W'($urandom_range(rsr_pkg::MEM_DEPTH + 1, 30));
            default: return rsr_pkg::CFG_W'($urandom_range(2, 15));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side. The ready line is decided at each falling edge, with random
    // gaps while idling is on and the long hold-off that a test may ask for.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_len == 0) begin
            hold_taken = 1'b0;
        end else if (!hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            sink_gap = pick_gap();
        end
    end

    // Every output transaction is compared with the oldest expected run record.
    always @(posedge i_clk) begin : run_checker
        t_run_rec want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_runs.size() == 0) begin
                mismatches++;
                $error("out_record %0d arrived with no transaction expected",
                       out_if.out_record);
            end else begin
                want = expected_runs.pop_front();
                if (out_if.out_record !== want.value) begin
                    mismatches++;
                    $error("out_record: expected %0d, got %0d", want.value, out_if.out_record);
                end
                if (out_if.run_end !== want.run_end) begin
                    mismatches++;
                    $error("run_end: expected %0b, got %0b", want.run_end, out_if.run_end);
                end
                if (out_if.last !== want.last) begin
                    mismatches++;
                    $error("last: expected %0b, got %0b", want.last, out_if.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one record after a random gap and waits until it is taken. The valid
    // line stays high afterwards, so that back-to-back records need no second
    // assignment within one time step; drain_and_settle lowers it.
    task automatic send_item(input logic signed [rsr_pkg::REC_W-1:0] rec, input logic fin);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.record   <= rec;
        in_if.is_final <= fin;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        take_record(rec, fin);
    endtask

    // Stops offering records, waits for every expected transaction and lets the
    // block settle, since a record that only fills the store leaves no trace.
    task automatic drain_and_settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_runs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_slots(input logic [rsr_pkg::CFG_W-1:0] count);
        drain_and_settle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        slots_cfg = count;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A file shorter than the store is drained in sorted order as it stands.
    task automatic test_short_final();
        send_item(REC_TOP, 1'b0);
        send_item(rsr_pkg::REC_MIN, 1'b0);
        send_item(0, 1'b1);
    endtask

    // Equal values go out from the lowest slot first; a record below the last one
    // sent is frozen, and the store freezing completely closes the run.
    task automatic test_ties_and_extremes();
        write_slots(2);
        send_item(-1, 1'b0);
        send_item(-1, 1'b0);
        send_item(REC_TOP, 1'b0);
        send_item(rsr_pkg::REC_MIN, 1'b0);
        send_item(0, 1'b1);
    endtask

    // A count of zero behaves as a single slot, so every smaller record ends a run.
    task automatic test_zero_slots();
        write_slots(0);
        send_item(5, 1'b0);
        send_item(3, 1'b0);
        send_item(7, 1'b0);
        send_item(rsr_pkg::REC_MIN, 1'b1);
    endtask

    // Raising the count mid-file lets further records fill the store, frozen when
    // they are below the last record sent; lowering it leaves them in selection.
    task automatic test_resize_midstream();
        write_slots(1);
        send_item(10, 1'b0);
        send_item(20, 1'b0);
        write_slots(3);
        send_item(5, 1'b0);
        send_item(30, 1'b0);
        send_item(1, 1'b0);
        write_slots(1);
        send_item(2, 1'b0);
        send_item(3, 1'b1);
    endtask

    // The receiver holds off for a long stretch while records keep coming, so the
    // output register fills and the block has to stop taking input.
    task automatic test_backpressure();
        int k;
        write_slots(2);
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        for (k = 0; k < 10; k++) begin
            send_item($urandom, k == 9);
        end
        drain_and_settle();
        hold_len = 0;
        idle_on  = 1'b1;
    endtask

    // Whole files of random length and character, each under a fresh register
    // setting, with the odd change of setting part way through a file.
    task automatic test_random_files();
        int                               sent;
        int                               len;
        int                               k;
        t_value_mode                      mode;
        logic signed [rsr_pkg::REC_W-1:0] rec;
        sent = 0;
        while (sent < RANDOM_RECORDS) begin
            write_slots(pick_slot_count());
            idle_on = ($urandom_range(0, 3) != 0);
            mode    = t_value_mode'($urandom_range(0, 4));
            walk    = $urandom;
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(40, 90);
            end else begin
                len = $urandom_range(1, 40);
            end
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    write_slots(pick_slot_count());
                end
                if ($urandom_range(0, 9) == 0) begin
                    rec = $urandom;
                end else begin
                    rec = draw_record(mode);
                end
                send_item(rec, k == len - 1);
            end
            sent += len;
        end
    endtask

    // Safety net against a hung handshake.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int i;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_if.valid    = 1'b0;
        in_if.record   = '0;
        in_if.is_final = 1'b0;
        out_if.ready   = 1'b0;
        slots_cfg      = rsr_pkg::CFG_W'(rsr_pkg::CFG_RESET);
        fill_cnt       = 0;
        last_out       = rsr_pkg::REC_MIN;
        walk           = '0;
        for (i = 0; i < rsr_pkg::MEM_DEPTH; i++) begin
            sto_val[i] = '0;
            sto_frz[i] = 1'b0;
            sto_vld[i] = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        test_short_final();
        test_ties_and_extremes();
        test_zero_slots();
        test_resize_midstream();
        test_backpressure();
        test_random_files();
        drain_and_settle();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
